// ----- sv/complex_arithmetic_unit_assert.svh -----
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("complex arithmetic unit assertion failed");
`define CAU_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("complex arithmetic unit reset assertion failed");
`else
`define CAU_ASSERT(lbl, prop)
`define CAU_ASSERT_NR(lbl, prop)
`endif

`endif

// ----- sv/cau_pkg.sv -----
// Package with shared constants and types of the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FUNC_W         = 3;

    localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CONJ = 3'd4;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic div_zero;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
        logic ovf;
    } t_ctrl;
endpackage
`default_nettype wire

// ----- sv/cau_front.sv -----
// Front end: operand products, simple results and divider setup, two stages.
`timescale 1ns / 1ps
`default_nettype none
module cau_front #(
    parameter int DW = cau_pkg::DATA_WIDTH_DEF,
    parameter int FB = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [cau_pkg::FUNC_W-1:0]   i_func,
    input  wire logic signed [DW-1:0]         i_a,
    input  wire logic signed [DW-1:0]         i_b,
    input  wire logic signed [DW-1:0]         i_c,
    input  wire logic signed [DW-1:0]         i_d,
    output cau_pkg::t_ctrl                    o_ctrl,
    output logic [DW-1:0]                     o_res_re,
    output logic [DW-1:0]                     o_res_im,
    output logic [2*DW+FB-1:0]                o_num_re,
    output logic [2*DW+FB-1:0]                o_num_im,
    output logic [2*DW-1:0]                   o_rem_re,
    output logic [2*DW-1:0]                   o_rem_im,
    output logic [2*DW-1:0]                   o_den
);
    import cau_pkg::*;

    localparam int PW    = 2 * DW;
    localparam int SW    = 2 * DW + 1;
    localparam int NUM_W = 2 * DW + FB;
    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [DW:0] sat(input logic signed [SW-1:0] x);
        logic [SW-DW:0] top;
        top = x[SW-1:DW-1];
        if (top == '0 || top == '1) begin
            return {1'b0, x[DW-1:0]};
        end
        return {1'b1, x[SW-1] ? SMIN : SMAX};
    endfunction

    logic                    r_s1_valid;
    logic [FUNC_W-1:0]       r_s1_func;
    logic                    r_s1_dz;
    logic signed [DW:0]      r_s1_re, r_s1_im;
    logic signed [PW-1:0]    r_pac, r_pbd, r_pad, r_pbc, r_pcc, r_pdd;
    logic signed [DW:0]      n_s1_re, n_s1_im;

    always_comb begin
        n_s1_re = '0;
        n_s1_im = '0;
        case (i_func)
            FUNC_ADD: begin
                n_s1_re = (DW+1)'(i_a) + (DW+1)'(i_c);
                n_s1_im = (DW+1)'(i_b) + (DW+1)'(i_d);
            end
            FUNC_SUB: begin
                n_s1_re = (DW+1)'(i_a) - (DW+1)'(i_c);
                n_s1_im = (DW+1)'(i_b) - (DW+1)'(i_d);
            end
            FUNC_CONJ: begin
                n_s1_re = (DW+1)'(i_a);
                n_s1_im = -(DW+1)'(i_b);
            end
            default: begin
                n_s1_re = '0;
                n_s1_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_func <= i_func;
            r_s1_dz   <= (i_c == '0) && (i_d == '0);
            r_s1_re   <= n_s1_re;
            r_s1_im   <= n_s1_im;
            r_pac     <= PW'(i_a) * PW'(i_c);
            r_pbd     <= PW'(i_b) * PW'(i_d);
            r_pad     <= PW'(i_a) * PW'(i_d);
            r_pbc     <= PW'(i_b) * PW'(i_c);
            r_pcc     <= PW'(i_c) * PW'(i_c);
            r_pdd     <= PW'(i_d) * PW'(i_d);
        end
    end

    logic signed [SW-1:0] mul_re, mul_im, nr, ni;
    logic [PW-1:0]        mag_re, mag_im, den;
    logic [NUM_W-1:0]     num_re, num_im;
    logic [DW:0]          sat_re, sat_im;
    t_ctrl                n_ctrl;

    always_comb begin
        mul_re = (SW'(r_pac) - SW'(r_pbd)) >>> FB;
        mul_im = (SW'(r_pad) + SW'(r_pbc)) >>> FB;
        nr     = SW'(r_pac) + SW'(r_pbd);
        ni     = SW'(r_pbc) - SW'(r_pad);
        mag_re = nr[SW-1] ? PW'(-nr) : PW'(nr);
        mag_im = ni[SW-1] ? PW'(-ni) : PW'(ni);
        num_re = NUM_W'(mag_re) << FB;
        num_im = NUM_W'(mag_im) << FB;
        den    = PW'(r_pcc) + PW'(r_pdd);
        sat_re = '0;
        sat_im = '0;
        case (r_s1_func)
            FUNC_ADD, FUNC_SUB, FUNC_CONJ: begin
                sat_re = sat(SW'(r_s1_re));
                sat_im = sat(SW'(r_s1_im));
            end
            FUNC_MUL: begin
                sat_re = sat(mul_re);
                sat_im = sat(mul_im);
            end
            default: begin
                sat_re = '0;
                sat_im = '0;
            end
        endcase
        n_ctrl.valid    = r_s1_valid;
        n_ctrl.is_div   = (r_s1_func == FUNC_DIV);
        n_ctrl.div_zero = (r_s1_func == FUNC_DIV) && r_s1_dz;
        n_ctrl.neg_re   = nr[SW-1];
        n_ctrl.neg_im   = ni[SW-1];
        n_ctrl.big_re   = (num_re >> (DW + 1)) >= NUM_W'(den);
        n_ctrl.big_im   = (num_im >> (DW + 1)) >= NUM_W'(den);
        n_ctrl.ovf      = sat_re[DW] | sat_im[DW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctrl.valid <= n_ctrl.valid;
        end
        if (i_en) begin
            o_ctrl.is_div   <= n_ctrl.is_div;
            o_ctrl.div_zero <= n_ctrl.div_zero;
            o_ctrl.neg_re   <= n_ctrl.neg_re;
            o_ctrl.neg_im   <= n_ctrl.neg_im;
            o_ctrl.big_re   <= n_ctrl.big_re;
            o_ctrl.big_im   <= n_ctrl.big_im;
            o_ctrl.ovf      <= n_ctrl.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res_re        <= sat_re[DW-1:0];
            o_res_im        <= sat_im[DW-1:0];
            o_num_re        <= num_re;
            o_num_im        <= num_im;
            o_rem_re        <= PW'(num_re >> (DW + 1));
            o_rem_im        <= PW'(num_im >> (DW + 1));
            o_den           <= den;
        end
    end
endmodule
`default_nettype wire

// ----- sv/cau_div_cell.sv -----
// One restoring division cell: develops one quotient bit of both parts.
`timescale 1ns / 1ps
`default_nettype none
module cau_div_cell #(
    parameter int DW      = cau_pkg::DATA_WIDTH_DEF,
    parameter int FB      = cau_pkg::FRAC_BITS_DEF,
    parameter int BIT_IDX = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire cau_pkg::t_ctrl        i_ctrl,
    input  wire logic [DW-1:0]         i_res_re,
    input  wire logic [DW-1:0]         i_res_im,
    input  wire logic [2*DW+FB-1:0]    i_num_re,
    input  wire logic [2*DW+FB-1:0]    i_num_im,
    input  wire logic [2*DW-1:0]       i_rem_re,
    input  wire logic [2*DW-1:0]       i_rem_im,
    input  wire logic [DW:0]           i_quo_re,
    input  wire logic [DW:0]           i_quo_im,
    input  wire logic [2*DW-1:0]       i_den,
    output cau_pkg::t_ctrl             o_ctrl,
    output logic [DW-1:0]              o_res_re,
    output logic [DW-1:0]              o_res_im,
    output logic [2*DW+FB-1:0]         o_num_re,
    output logic [2*DW+FB-1:0]         o_num_im,
    output logic [2*DW-1:0]            o_rem_re,
    output logic [2*DW-1:0]            o_rem_im,
    output logic [DW:0]                o_quo_re,
    output logic [DW:0]                o_quo_im,
    output logic [2*DW-1:0]            o_den
);
    import cau_pkg::*;

    localparam int RW = 2 * DW;

    logic [RW:0]   t_re, t_im, den_x;
    logic          ge_re, ge_im;
    logic [RW-1:0] n_rem_re, n_rem_im;

    always_comb begin
        den_x    = {1'b0, i_den};
        t_re     = {i_rem_re, i_num_re[BIT_IDX]};
        t_im     = {i_rem_im, i_num_im[BIT_IDX]};
        ge_re    = t_re >= den_x;
        ge_im    = t_im >= den_x;
        n_rem_re = ge_re ? RW'(t_re - den_x) : RW'(t_re);
        n_rem_im = ge_im ? RW'(t_im - den_x) : RW'(t_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctrl.valid <= i_ctrl.valid;
        end
        if (i_en) begin
            o_ctrl.is_div   <= i_ctrl.is_div;
            o_ctrl.div_zero <= i_ctrl.div_zero;
            o_ctrl.neg_re   <= i_ctrl.neg_re;
            o_ctrl.neg_im   <= i_ctrl.neg_im;
            o_ctrl.big_re   <= i_ctrl.big_re;
            o_ctrl.big_im   <= i_ctrl.big_im;
            o_ctrl.ovf      <= i_ctrl.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res_re        <= i_res_re;
            o_res_im        <= i_res_im;
            o_num_re        <= i_num_re;
            o_num_im        <= i_num_im;
            o_rem_re        <= n_rem_re;
            o_rem_im        <= n_rem_im;
            o_quo_re        <= {i_quo_re[DW-1:0], ge_re};
            o_quo_im        <= {i_quo_im[DW-1:0], ge_im};
            o_den           <= i_den;
        end
    end
endmodule
`default_nettype wire

// ----- sv/complex_arithmetic_unit.sv -----
// Top level of the complex arithmetic unit: front end, divider cell row, output stage.
// The unit takes one request per cycle while o_ready is high and returns one result
// per request, in order. Every operation passes the front end's product and setup
// stages, a row of DATA_WIDTH + 1 division cells (each cell develops one quotient bit
// of both result parts), and the output register.
// A stall on the result side holds the whole pipeline; ready falls only then.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [cau_pkg::FUNC_W-1:0]  i_func,
    input  wire logic signed [DATA_WIDTH-1:0] i_lhs_real,
    input  wire logic signed [DATA_WIDTH-1:0] i_lhs_imag,
    input  wire logic signed [DATA_WIDTH-1:0] i_rhs_real,
    input  wire logic signed [DATA_WIDTH-1:0] i_rhs_imag,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic signed [DATA_WIDTH-1:0]     o_res_real,
    output logic signed [DATA_WIDTH-1:0]     o_res_imag,
    output logic                             o_div_zero,
    output logic                             o_overflow
);
    import cau_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int NCELL = DW + 1;
    localparam int NUM_W = 2 * DW + FRAC_BITS;
    localparam int RW    = 2 * DW;
    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW:0]   HALF = (DW+1)'(1) << (DW - 1);

    logic r_valid;
    logic en;
    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    t_ctrl             ctrl   [0:NCELL];
    logic [DW-1:0]     res_re [0:NCELL];
    logic [DW-1:0]     res_im [0:NCELL];
    logic [NUM_W-1:0]  num_re [0:NCELL];
    logic [NUM_W-1:0]  num_im [0:NCELL];
    logic [RW-1:0]     rem_re [0:NCELL];
    logic [RW-1:0]     rem_im [0:NCELL];
    logic [DW:0]       quo_re [0:NCELL];
    logic [DW:0]       quo_im [0:NCELL];
    logic [RW-1:0]     den    [0:NCELL];

    assign quo_re[0] = '0;
    assign quo_im[0] = '0;

    cau_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_a      (i_lhs_real),
        .i_b      (i_lhs_imag),
        .i_c      (i_rhs_real),
        .i_d      (i_rhs_imag),
        .o_ctrl   (ctrl[0]),
        .o_res_re (res_re[0]),
        .o_res_im (res_im[0]),
        .o_num_re (num_re[0]),
        .o_num_im (num_im[0]),
        .o_rem_re (rem_re[0]),
        .o_rem_im (rem_im[0]),
        .o_den    (den[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        cau_div_cell #(.DW(DW), .FB(FRAC_BITS), .BIT_IDX(DW - k)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_ctrl   (ctrl[k]),
            .i_res_re (res_re[k]),
            .i_res_im (res_im[k]),
            .i_num_re (num_re[k]),
            .i_num_im (num_im[k]),
            .i_rem_re (rem_re[k]),
            .i_rem_im (rem_im[k]),
            .i_quo_re (quo_re[k]),
            .i_quo_im (quo_im[k]),
            .i_den    (den[k]),
            .o_ctrl   (ctrl[k+1]),
            .o_res_re (res_re[k+1]),
            .o_res_im (res_im[k+1]),
            .o_num_re (num_re[k+1]),
            .o_num_im (num_im[k+1]),
            .o_rem_re (rem_re[k+1]),
            .o_rem_im (rem_im[k+1]),
            .o_quo_re (quo_re[k+1]),
            .o_quo_im (quo_im[k+1]),
            .o_den    (den[k+1])
        );
    end

    function automatic logic [DW:0] div_sat(input logic [DW:0] q, input logic neg,
                                            input logic big);
        logic [DW:0] nq;
        nq = ~q + 1'b1;
        if (neg) begin
            if (big || q > HALF) begin
                return {1'b1, SMIN};
            end
            return {1'b0, nq[DW-1:0]};
        end
        if (big || q >= HALF) begin
            return {1'b1, SMAX};
        end
        return {1'b0, q[DW-1:0]};
    endfunction

    t_ctrl         last;
    logic [DW:0]   dq_re, dq_im;
    logic [DW-1:0] n_res_re, n_res_im;
    logic          n_ovf;

    always_comb begin
        last  = ctrl[NCELL];
        dq_re = div_sat(quo_re[NCELL], last.neg_re, last.big_re);
        dq_im = div_sat(quo_im[NCELL], last.neg_im, last.big_im);
        if (last.div_zero) begin
            n_res_re = '0;
            n_res_im = '0;
            n_ovf    = 1'b0;
        end else if (last.is_div) begin
            n_res_re = dq_re[DW-1:0];
            n_res_im = dq_im[DW-1:0];
            n_ovf    = dq_re[DW] | dq_im[DW];
        end else begin
            n_res_re = res_re[NCELL];
            n_res_im = res_im[NCELL];
            n_ovf    = last.ovf;
        end
    end

    logic [DW-1:0] r_res_re, r_res_im;
    logic          r_div_zero, r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_re   <= n_res_re;
            r_res_im   <= n_res_im;
            r_div_zero <= last.div_zero;
            r_ovf      <= n_ovf;
        end
    end

    assign o_valid    = r_valid;
    assign o_res_real = r_res_re;
    assign o_res_imag = r_res_im;
    assign o_div_zero = r_div_zero;
    assign o_overflow = r_ovf;

    logic re_at_lim, im_at_lim;
    assign re_at_lim = (o_res_real == SMAX) || (o_res_real == SMIN);
    assign im_at_lim = (o_res_imag == SMAX) || (o_res_imag == SMIN);

    `CAU_ASSERT(a_dz_zero, o_valid && o_div_zero |-> !o_overflow && (o_res_real | o_res_imag) == '0)
    `CAU_ASSERT(a_ovf_sat, o_valid && o_overflow |-> re_at_lim || im_at_lim)
    `CAU_ASSERT_NR(a_rst_empty, !i_rst_n |=> !o_valid)
endmodule
`default_nettype wire

// ----- tb/sv/complex_arithmetic_unit_test.sv -----
// Testbench of the complex arithmetic unit with a scoreboard and randomized requests.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit_test;
    import cau_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int LATENCY = DW + 4;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic dz;
        logic ovf;
    } t_cplx_res;

    int n_errors = 0;

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    class cplx_scoreboard;
        t_cplx_res pending[$];

        function logic [DW-1:0] saturate(input logic signed [127:0] x, inout logic ovf);
            logic signed [127:0] hi_lim;
            logic signed [127:0] lo_lim;
            hi_lim = (128'sd1 <<< (DW - 1)) - 1;
            lo_lim = -(128'sd1 <<< (DW - 1));
            if (x > hi_lim) begin
                ovf = 1'b1;
                return hi_lim[DW-1:0];
            end
            if (x < lo_lim) begin
                ovf = 1'b1;
                return lo_lim[DW-1:0];
            end
            return x[DW-1:0];
        endfunction

        function logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                input logic signed [127:0] d);
            logic [127:0] q;
            logic signed [127:0] an;
            an = (n < 0) ? -n : n;
            q = $unsigned(an) / $unsigned(d);
            return (n < 0) ? -$signed(q) : $signed(q);
        endfunction

        function void note_request(input logic [FUNC_W-1:0] f,
                                   input logic signed [DW-1:0] a,
                                   input logic signed [DW-1:0] b,
                                   input logic signed [DW-1:0] c,
                                   input logic signed [DW-1:0] d);
            logic signed [127:0] ea, eb, ec, ed, re, im, den;
            t_cplx_res r;
            logic valid;
            logic ovf;
            ea = a; eb = b; ec = c; ed = d;
            re = 0; im = 0;
            r.dz = 1'b0; r.ovf = 1'b0;
            ovf = 1'b0;
            valid = 1'b1;
            case (f)
                FUNC_ADD: begin re = ea + ec; im = eb + ed; end
                FUNC_SUB: begin re = ea - ec; im = eb - ed; end
                FUNC_MUL: begin
                    re = (ea * ec - eb * ed) >>> FB;
                    im = (ea * ed + eb * ec) >>> FB;
                end
                FUNC_DIV: begin
                    if (c == 0 && d == 0) begin
                        r.dz = 1'b1;
                        valid = 1'b0;
                    end else begin
                        den = ec * ec + ed * ed;
                        re = trunc_div((ea * ec + eb * ed) <<< FB, den);
                        im = trunc_div((eb * ec - ea * ed) <<< FB, den);
                    end
                end
                FUNC_CONJ: begin re = ea; im = -eb; end
                default: valid = 1'b0;
            endcase
            if (valid) begin
                r.re = saturate(re, ovf);
                r.im = saturate(im, ovf);
            end else begin
                r.re = '0;
                r.im = '0;
            end
            r.ovf = ovf;
            pending.push_back(r);
        endfunction

        task check_result(input logic [DW-1:0] re, input logic [DW-1:0] im,
                          input logic dz, input logic ovf);
            t_cplx_res w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", re, '0);
                return;
            end
            w = pending.pop_front();
            if (re !== w.re) report_mismatch("res_real", re, w.re);
            if (im !== w.im) report_mismatch("res_imag", im, w.im);
            if (dz !== w.dz) report_mismatch("div_zero", dz, w.dz);
            if (ovf !== w.ovf) report_mismatch("overflow", ovf, w.ovf);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [FUNC_W-1:0] i_func = '0;
    logic signed [DW-1:0] i_lhs_real = '0;
    logic signed [DW-1:0] i_lhs_imag = '0;
    logic signed [DW-1:0] i_rhs_real = '0;
    logic signed [DW-1:0] i_rhs_imag = '0;
    logic o_ready;
    logic o_valid;
    logic signed [DW-1:0] o_res_real;
    logic signed [DW-1:0] o_res_imag;
    logic o_div_zero;
    logic o_overflow;

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_lhs_real(i_lhs_real), .i_lhs_imag(i_lhs_imag),
        .i_rhs_real(i_rhs_real), .i_rhs_imag(i_rhs_imag), .o_valid(o_valid),
        .i_ready(i_ready), .o_res_real(o_res_real), .o_res_imag(o_res_imag),
        .o_div_zero(o_div_zero), .o_overflow(o_overflow)
    );

    cplx_scoreboard results = new();
    bit quiet_rx = 1'b0;
    bit hold_rx = 1'b0;
    bit hold_done = 1'b0;
    int idle_pct = 20;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            results.note_request(i_func, i_lhs_real, i_lhs_imag, i_rhs_real, i_rhs_imag);
        if (i_rst_n && o_valid && i_ready)
            results.check_result(o_res_real, o_res_imag, o_div_zero, o_overflow);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx)
            i_ready <= 1'b0;
        else
            i_ready <= quiet_rx || ($urandom_range(99) >= idle_pct);
    end

    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'h0001_0000;
            4: return 32'hffff_0000;
            5, 6: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [DW-1:0] a,
                                input logic [DW-1:0] b, input logic [DW-1:0] c,
                                input logic [DW-1:0] d);
        i_valid <= 1'b1;
        i_func <= f;
        i_lhs_real <= a;
        i_lhs_imag <= b;
        i_rhs_real <= c;
        i_rhs_imag <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic pause_sender(input bit allow_idle);
        if (allow_idle && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin
        logic [FUNC_W-1:0] f;
        logic [DW-1:0] a, b, c, d;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
        send_request(FUNC_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
        send_request(FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
        send_request(FUNC_SUB, 32'h0005_8000, 32'hfff0_0000, 32'h0001_0000, 32'h0002_0000);
        send_request(FUNC_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hfffb_0000);
        send_request(FUNC_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_request(FUNC_MUL, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
        send_request(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(FUNC_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hffff_0000);
        send_request(FUNC_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000);
        send_request(FUNC_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h0003_0000, 32'h0000_0000);
        send_request(FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(FUNC_DIV, 32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(FUNC_CONJ, 32'h0001_0000, 32'h8000_0000, 32'h1234_5678, 32'h0);
        send_request(FUNC_CONJ, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
        send_request(3'd5, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_request(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_request(3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
        drain();

        for (int n = 0; n < 1100; n++) begin
            if (n == 200) begin
                drain();
                idle_pct = 0;
                quiet_rx = 1'b1;
            end
            if (n == 400) begin
                idle_pct = 20;
                quiet_rx = 1'b0;
            end
            if (n == 500) begin
                hold_rx = 1'b1;
                fork
                    begin
                        repeat (3 * LATENCY) @(posedge i_clk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            if (n == 800) drain();
            f = ($urandom_range(19) == 0) ? FUNC_W'($urandom_range(7, 5))
                                          : FUNC_W'($urandom_range(4));
            a = pick_value();
            b = pick_value();
            c = pick_value();
            d = pick_value();
            if (f == FUNC_DIV && $urandom_range(15) == 0) begin
                c = '0;
                d = '0;
            end
            send_request(f, a, b, c, d);
            pause_sender(1'b1);
        end
        drain();
        if (n_errors == 0 && results.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_div_cell.sv
sv/complex_arithmetic_unit.sv
tb/sv/complex_arithmetic_unit_test.sv
